/* hw/rtl/font_unicode_table_parser_assert.svh */
// Assertion macros shared by the font Unicode table parser RTL.
`ifndef FONT_UNICODE_TABLE_PARSER_ASSERT_SVH
`define FONT_UNICODE_TABLE_PARSER_ASSERT_SVH

// Checks a property on every rising edge of clk_i while out of reset.
`define FONTUT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define FONTUT_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> (conseq)) else $error(msg);

`endif

/* hw/rtl/fontut_pkg.sv */
// Types and constants for the font Unicode table parser.
`timescale 1ns / 1ps
package fontut_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CodeW    = 21;
  localparam int unsigned GlyphW   = 16;
  localparam int unsigned PendW    = 2;
  localparam int unsigned FmtW     = 2;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 2;
  localparam int unsigned OutDataW = 40;

  typedef logic [ByteW-1:0]    byte_t;
  typedef logic [CodeW-1:0]    code_t;
  typedef logic [GlyphW-1:0]   glyph_t;
  typedef logic [PendW-1:0]    pend_t;
  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;
  typedef logic [OutDataW-1:0] out_data_t;

  typedef enum logic [FmtW-1:0] {
    FmtUndef0 = 2'd0,
    FmtV1     = 2'd1,
    FmtV2     = 2'd2,
    FmtUndef3 = 2'd3
  } fmt_e;

  localparam cfg_idx_t RegFormat   = 1'b0;
  localparam cfg_idx_t RegGlyphs512 = 1'b1;

  localparam byte_t GlyphEndByte = 8'hFF;
  localparam byte_t SkipByte     = 8'hFE;

endpackage

/* hw/rtl/font_unicode_table_parser.sv */
// Top level of the font Unicode table parser: UTF-8 decode of table bytes.
//
// Channel     Dir  Fields (tdata from bit 0 up)
// s_axis      in   table_byte[7:0]
// m_axis      out  codepoint[20:0], glyph_index[36:21], zero fill[39:37]
// cfg         in   index 0 format_version, index 1 glyphs_512
//
// One byte per cycle is accepted while m_axis is not stalled. The byte sits in an
// input register, is decoded against the sequence state and the pair lands in the
// output register. rst_ni clears control state and glyphs_512, and sets FmtV1.
// A stall on m_axis holds both stages; s_axis keeps taking bytes while they move.
`timescale 1ns / 1ps
`include "font_unicode_table_parser_assert.svh"

module font_unicode_table_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  fontut_pkg::byte_t      s_axis_tdata_i,   // table_byte[7:0]
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output fontut_pkg::out_data_t  m_axis_tdata_o,   // codepoint[20:0], glyph_index[36:21]
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  fontut_pkg::cfg_idx_t   cfg_index_i,
  input  fontut_pkg::cfg_data_t  cfg_data_i
);
  import fontut_pkg::*;

  fmt_e   fmt_q;
  logic   glyphs_512_q;
  logic   in_valid_q;
  byte_t  in_byte_q;
  glyph_t counter_q, counter_d;
  pend_t  pend_q, pend_d;
  code_t  partial_q, partial_d;
  logic   out_valid_q;
  code_t  out_code_q;
  glyph_t out_glyph_q;

  logic   advance;
  logic   fmt2;
  logic   at_limit;
  logic   finish;
  code_t  value;
  logic   emit;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_glyph_q, out_code_q};

  assign fmt2     = (fmt_q == FmtV2);
  assign at_limit = glyphs_512_q ? (counter_q[15:9] != 7'd0) : (counter_q[15:8] != 8'd0);

  always_comb begin
    counter_d = counter_q;
    pend_d    = pend_q;
    partial_d = partial_q;
    finish    = 1'b0;
    value     = {{(CodeW-ByteW){1'b0}}, in_byte_q};
    if (pend_q != 2'd0) begin
      partial_d = {partial_q[CodeW-7:0], in_byte_q[5:0]};
      pend_d    = pend_q - 2'd1;
      finish    = (pend_q == 2'd1);
      value     = partial_d;
    end else if (fmt2 || !at_limit) begin
      priority if (in_byte_q == GlyphEndByte) begin
        counter_d = counter_q + 16'd1;
      end else if (in_byte_q == SkipByte) begin
        counter_d = counter_q;
      end else if (!in_byte_q[7]) begin
        finish = 1'b1;
      end else if (fmt2) begin
        // Format 2 tests one lead bit at a time.
        priority if (!in_byte_q[5]) begin
          partial_d = {16'd0, in_byte_q[4:0]};
          pend_d    = 2'd1;
        end else if (!in_byte_q[4]) begin
          partial_d = {17'd0, in_byte_q[3:0]};
          pend_d    = 2'd2;
        end else if (!in_byte_q[3]) begin
          partial_d = {18'd0, in_byte_q[2:0]};
          pend_d    = 2'd3;
        end else begin
          pend_d = 2'd0;
        end
      end else begin
        priority if (in_byte_q[7:5] == 3'b110) begin
          partial_d = {16'd0, in_byte_q[4:0]};
          pend_d    = 2'd1;
        end else if (in_byte_q[7:4] == 4'b1110) begin
          partial_d = {17'd0, in_byte_q[3:0]};
          pend_d    = 2'd2;
        end else begin
          pend_d = 2'd0;
        end
      end
    end
  end

  // Format 1 only passes values in the basic plane, excluding 0xFFFF.
  assign emit = finish && (value != '0) &&
                (fmt2 || ((value[20:16] == 5'd0) && (value[15:0] != 16'hFFFF)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q        <= FmtV1;
      glyphs_512_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegFormat:    fmt_q        <= fmt_e'(cfg_data_i);
        RegGlyphs512: glyphs_512_q <= cfg_data_i[0];
        default:      fmt_q        <= fmt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      counter_q   <= '0;
      pend_q      <= '0;
      partial_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q && emit;
        if (in_valid_q) begin
          counter_q <= counter_d;
          pend_q    <= pend_d;
          partial_q <= partial_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (advance && in_valid_q && emit) begin
      out_code_q  <= value;
      out_glyph_q <= counter_q;
    end
  end

  `FONTUT_ASSERT(a_out_nonzero, !out_valid_q || (out_code_q != '0), "zero codepoint emitted")
  `FONTUT_ASSERT_NEXT(a_counter_step, 1'b1,
    (counter_q == $past(counter_q)) || (counter_q == $past(counter_q) + 16'd1),
    "glyph counter jumped")
  `FONTUT_ASSERT_NEXT(a_counter_hold_mid_seq, pend_q != 2'd0, $stable(counter_q),
    "glyph counter moved inside a sequence")
  `FONTUT_ASSERT_NEXT(a_stall_holds_input, in_valid_q && !advance, in_valid_q && $stable(in_byte_q),
    "input register lost an item during a stall")

endmodule
